FILE: rtl/lbsc_pkg.sv
// Shared constants, types and register codes for the braking speed command core.
package lbsc_pkg;

   // Block configuration
   localparam int AXES      = 2;
   localparam int FRAC_BITS = 16;

   // Field widths
   localparam int DATA_W     = 32;
   localparam int TIME_W     = 16;
   localparam int MASS_W     = 16;
   localparam int LIM_W      = 24;
   localparam int UNL_W      = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Distance error and force product
   localparam int PROD_A_W = DATA_W + TIME_W + 1;
   localparam int DERR_W   = DATA_W + TIME_W + 2;
   localparam int LEN_W    = DERR_W - 1;
   localparam int LEN_LO_W = 25;
   localparam int LEN_HI_W = LEN_W - LEN_LO_W;
   localparam int PL_W     = LEN_LO_W + LIM_W;
   localparam int PH_W     = LEN_HI_W + LIM_W;
   localparam int PROD_W   = LEN_W + LIM_W;

   // Dividers: brake numerator is the force product scaled down, ideal is |dist| << 16
   localparam int BR_SH    = 25 - FRAC_BITS;
   localparam int BR_NW    = PROD_W - BR_SH;
   localparam int IDEAL_NW = DATA_W + TIME_W;
   localparam int DIV_W    = (BR_NW > IDEAL_NW) ? BR_NW : IDEAL_NW;
   localparam int REM_W    = TIME_W;
   localparam int DVS_W    = TIME_W;
   localparam int QX_W     = 80;

   // Square root
   localparam int RAD_W    = 64;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int SQ_REM_W = ROOT_W + 2;
   localparam int SQ_STEPS = ROOT_W;

   // Speed magnitudes and signed result
   localparam int MAG_W = 34;
   localparam logic [MAG_W-1:0] SPD_CAP = MAG_W'(1) << (MAG_W - 1);
   localparam int RES_W = MAG_W + 2;
   localparam logic signed [RES_W-1:0] RES_MAX = (RES_W'(1) <<< (DATA_W - 1)) - RES_W'(1);
   localparam logic signed [RES_W-1:0] RES_MIN = -(RES_W'(1) <<< (DATA_W - 1));

   // Front stages plus one cell per quotient bit and per root bit
   localparam int FRONT_STAGES = 4;
   localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_W + SQ_STEPS;

   // Register reset values
   localparam logic [MASS_W-1:0] MASS_RST = MASS_W'(500);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MASS     = 3'd0,
      CSR_LIM_PX   = 3'd1,
      CSR_LIM_PY   = 3'd2,
      CSR_LIM_NX   = 3'd3,
      CSR_LIM_NY   = 3'd4,
      CSR_UNL_MASK = 3'd5
   } csr_idx_type;

   // Per-axis configuration handed to a lane
   typedef struct packed {
      logic [MASS_W-1:0] mass;
      logic [LIM_W-1:0]  lim_pos;
      logic [LIM_W-1:0]  lim_neg;
      logic              unl_pos;
      logic              unl_neg;
   } axis_cfg_type;

   // Per-item flags that ride along the cell chain
   typedef struct packed {
      logic [DATA_W-1:0] match;
      logic              d_zero;
      logic              unl;
      logic              dist_neg;
      logic              d_neg;
      logic              lim_zero;
      logic              mass_zero;
      logic              ovf;
      logic [MAG_W-1:0]  ideal;
   } side_type;

endpackage

FILE: rtl/linear_braking_speed_command_core.sv
// Top level: configuration registers, per-axis lanes, valid tracking and output register.
// Registers from item accept to rsp_valid, in order:
// four front stages, one divider cell per quotient bit (64), one root cell per bit (32),
// and the output register. Throughput: one item per cycle; the whole chain advances together
// and holds only while a result waits in the output register.
// Reset: synchronous; clears all valid bits and loads register reset values (mass 500).
module linear_braking_speed_command_core import lbsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [DATA_W-1:0]     req_dist_x,
   input  logic [DATA_W-1:0]     req_dist_y,
   input  logic [DATA_W-1:0]     req_match_vel_x,
   input  logic [DATA_W-1:0]     req_match_vel_y,
   input  logic [TIME_W-1:0]     req_frame_time,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_W-1:0]     rsp_speed_x,
   output logic [DATA_W-1:0]     rsp_speed_y,
   output logic                  rsp_saturated,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [MASS_W-1:0] mass_ff;
   logic [LIM_W-1:0]  lim_px_ff, lim_py_ff, lim_nx_ff, lim_ny_ff;
   logic [UNL_W-1:0]  unl_ff;

   logic              adv;
   logic              vld_ff [PIPE_DEPTH];
   logic              out_vld_ff;
   logic [DATA_W-1:0] spd_x_ff, spd_y_ff;
   logic              sat_ff;

   logic [DATA_W-1:0] dist_a  [2];
   logic [DATA_W-1:0] match_a [2];
   axis_cfg_type      cfg_a   [2];
   logic [DATA_W-1:0] spd_a   [2];
   logic              sat_a   [2];

   // Write configuration registers; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff   <= MASS_RST;
         lim_px_ff <= '0;
         lim_py_ff <= '0;
         lim_nx_ff <= '0;
         lim_ny_ff <= '0;
         unl_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_MASS:     mass_ff   <= csr_wdata[MASS_W-1:0];
            CSR_LIM_PX:   lim_px_ff <= csr_wdata[LIM_W-1:0];
            CSR_LIM_PY:   lim_py_ff <= csr_wdata[LIM_W-1:0];
            CSR_LIM_NX:   lim_nx_ff <= csr_wdata[LIM_W-1:0];
            CSR_LIM_NY:   lim_ny_ff <= csr_wdata[LIM_W-1:0];
            CSR_UNL_MASK: unl_ff    <= csr_wdata[UNL_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance the chain unless a result is held in the output register
   assign adv       = !out_vld_ff || rsp_ready;
   assign req_ready = adv;

   // Route per-axis inputs and configuration
   assign dist_a[0]  = req_dist_x;
   assign dist_a[1]  = req_dist_y;
   assign match_a[0] = req_match_vel_x;
   assign match_a[1] = req_match_vel_y;
   assign cfg_a[0]   = '{mass: mass_ff, lim_pos: lim_px_ff, lim_neg: lim_nx_ff,
                         unl_pos: unl_ff[0], unl_neg: unl_ff[2]};
   assign cfg_a[1]   = '{mass: mass_ff, lim_pos: lim_py_ff, lim_neg: lim_ny_ff,
                         unl_pos: unl_ff[1], unl_neg: unl_ff[3]};

   for (genvar i = 0; i < 2; i++) begin : g_axis
      if (i < AXES) begin : g_on
         lbsc_lane u_lane (
            .clock    (clock),
            .adv      (adv),
            .dist_val ($signed(dist_a[i])),
            .match    ($signed(match_a[i])),
            .ftime    (req_frame_time),
            .cfg      (cfg_a[i]),
            .speed    (spd_a[i]),
            .sat      (sat_a[i])
         );
      end else begin : g_off
         assign spd_a[i] = '0;
         assign sat_a[i] = 1'b0;
      end
   end

   // Track which chain stages hold an item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            vld_ff[k] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < PIPE_DEPTH; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         out_vld_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   // Hold the finished item until taken
   always_ff @(posedge clock) begin
      if (adv) begin
         spd_x_ff <= spd_a[0];
         spd_y_ff <= spd_a[1];
         sat_ff   <= sat_a[0] | sat_a[1];
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_speed_x   = spd_x_ff;
   assign rsp_speed_y   = spd_y_ff;
   assign rsp_saturated = sat_ff;

endmodule

FILE: rtl/lbsc_div_cell.sv
// One restoring division cell: produces one quotient bit and hands on to the next cell.
module lbsc_div_cell import lbsc_pkg::*; (
   input  logic             clock,
   input  logic             adv,
   input  logic [REM_W-1:0] rem_i,
   input  logic [DIV_W-1:0] num_i,
   input  logic [DVS_W-1:0] dvs_i,
   output logic [REM_W-1:0] rem_o,
   output logic [DIV_W-1:0] num_o,
   output logic [DVS_W-1:0] dvs_o
);

   logic [REM_W:0]   trial;
   logic [REM_W:0]   diff;
   logic             ge;
   logic [REM_W-1:0] rem_in, rem_ff;
   logic [DIV_W-1:0] num_in, num_ff;
   logic [DVS_W-1:0] dvs_ff;

   // Bring down the next numerator bit and try the subtract
   always_comb begin
      trial  = {rem_i, num_i[DIV_W-1]};
      ge     = (trial >= {1'b0, dvs_i});
      diff   = trial - {1'b0, dvs_i};
      rem_in = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      num_in = {num_i[DIV_W-2:0], ge};
   end

   // Advance to the neighbor
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         dvs_ff <= dvs_i;
      end
   end

   assign rem_o = rem_ff;
   assign num_o = num_ff;
   assign dvs_o = dvs_ff;

endmodule

FILE: rtl/lbsc_sqrt_cell.sv
// One digit-by-digit square root cell: produces one root bit per cycle while the chain advances.
module lbsc_sqrt_cell import lbsc_pkg::*; (
   input  logic                clock,
   input  logic                adv,
   input  logic [RAD_W-1:0]    rad_i,
   input  logic [SQ_REM_W-1:0] rem_i,
   input  logic [ROOT_W-1:0]   root_i,
   output logic [RAD_W-1:0]    rad_o,
   output logic [SQ_REM_W-1:0] rem_o,
   output logic [ROOT_W-1:0]   root_o
);

   logic [SQ_REM_W+1:0] trial;
   logic [SQ_REM_W+1:0] test;
   logic [SQ_REM_W+1:0] diff;
   logic                ge;
   logic [RAD_W-1:0]    rad_in, rad_ff;
   logic [SQ_REM_W-1:0] rem_in, rem_ff;
   logic [ROOT_W-1:0]   root_in, root_ff;

   // Bring down two radicand bits and try 4*root+1
   always_comb begin
      trial   = {rem_i, rad_i[RAD_W-1 -: 2]};
      test    = (SQ_REM_W + 2)'({root_i, 2'b01});
      ge      = (trial >= test);
      diff    = trial - test;
      rem_in  = ge ? diff[SQ_REM_W-1:0] : trial[SQ_REM_W-1:0];
      root_in = {root_i[ROOT_W-2:0], ge};
      rad_in  = rad_i << 2;
   end

   // Advance to the neighbor
   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

FILE: rtl/lbsc_lane.sv
// One axis: distance error, force product, two divider chains, root chain and final combine.
module lbsc_lane import lbsc_pkg::*; (
   input  logic                     clock,
   input  logic                     adv,
   input  logic signed [DATA_W-1:0] dist_val,
   input  logic signed [DATA_W-1:0] match,
   input  logic [TIME_W-1:0]        ftime,
   input  axis_cfg_type             cfg,
   output logic [DATA_W-1:0]        speed,
   output logic                     sat
);

   // Stage 1: match * frame_time
   logic signed [DATA_W-1:0]   s1_dist_ff, s1_match_ff;
   logic [TIME_W-1:0]          s1_time_ff;
   logic signed [PROD_A_W-1:0] s1_prod_in, s1_prod_ff;

   // Stage 2: distance error and direction
   logic signed [DERR_W-1:0] derr;
   logic signed [DERR_W-1:0] derr_abs;
   logic signed [DATA_W:0]   dist_x;
   logic [DATA_W:0]          dist_abs;
   logic [LEN_W-1:0]         s2_len_ff;
   logic [LIM_W-1:0]         s2_lim_in, s2_lim_ff;
   logic [IDEAL_NW-1:0]      s2_inum_ff;
   logic [TIME_W-1:0]        s2_time_ff;
   side_type                 s2_side_in, s2_side_ff;

   // Stage 3: split force product
   logic [PL_W-1:0]     s3_pl_ff;
   logic [PH_W-1:0]     s3_ph_ff;
   logic [IDEAL_NW-1:0] s3_inum_ff;
   logic [TIME_W-1:0]   s3_time_ff;
   side_type            s3_side_ff;

   // Stage 4: scaled brake numerator
   logic [PROD_W-1:0]   prod_sum;
   logic [BR_NW-1:0]    s4_bnum_in, s4_bnum_ff;
   logic [IDEAL_NW-1:0] s4_inum_ff;
   logic [TIME_W-1:0]   s4_time_ff;
   side_type            s4_side_ff;

   // Divider chains
   logic [REM_W-1:0] br_rem [DIV_W+1];
   logic [DIV_W-1:0] br_num [DIV_W+1];
   logic [DVS_W-1:0] br_dvs [DIV_W+1];
   logic [REM_W-1:0] id_rem [DIV_W+1];
   logic [DIV_W-1:0] id_num [DIV_W+1];
   logic [DVS_W-1:0] id_dvs [DIV_W+1];
   side_type         dv_side_ff [DIV_W];

   // Root chain
   logic [QX_W-1:0]     qx;
   logic [DIV_W-1:0]    iq;
   side_type            sq_side_in;
   logic [RAD_W-1:0]    sq_rad  [SQ_STEPS+1];
   logic [SQ_REM_W-1:0] sq_rem  [SQ_STEPS+1];
   logic [ROOT_W-1:0]   sq_root [SQ_STEPS+1];
   side_type            sq_side_ff [SQ_STEPS];

   // Final combine
   side_type                 fin;
   logic [MAG_W-1:0]         mag_raw;
   logic [MAG_W-1:0]         mag;
   logic signed [RES_W-1:0]  mext, iext, mval, res;

   // Form match * frame_time
   assign s1_prod_in = PROD_A_W'(match) * PROD_A_W'($signed({1'b0, ftime}));

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_dist_ff  <= dist_val;
         s1_match_ff <= match;
         s1_time_ff  <= ftime;
         s1_prod_ff  <= s1_prod_in;
      end
   end

   // Form the distance error and pick the force limit for its direction
   always_comb begin
      derr     = (DERR_W'(s1_dist_ff) <<< TIME_W) - DERR_W'(s1_prod_ff);
      derr_abs = derr[DERR_W-1] ? -derr : derr;
      dist_x   = (DATA_W + 1)'(s1_dist_ff);
      dist_abs = dist_x[DATA_W] ? (DATA_W + 1)'(-dist_x) : (DATA_W + 1)'(dist_x);
      s2_lim_in = derr[DERR_W-1] ? cfg.lim_neg : cfg.lim_pos;
      s2_side_in.match     = s1_match_ff;
      s2_side_in.d_zero    = (derr == '0);
      s2_side_in.unl       = derr[DERR_W-1] ? cfg.unl_neg : cfg.unl_pos;
      s2_side_in.dist_neg  = s1_dist_ff[DATA_W-1];
      s2_side_in.d_neg     = derr[DERR_W-1];
      s2_side_in.lim_zero  = (s2_lim_in == '0);
      s2_side_in.mass_zero = (cfg.mass == '0);
      s2_side_in.ovf       = 1'b0;
      s2_side_in.ideal     = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_len_ff  <= derr_abs[LEN_W-1:0];
         s2_lim_ff  <= s2_lim_in;
         s2_inum_ff <= {dist_abs[DATA_W-1:0], {TIME_W{1'b0}}};
         s2_time_ff <= s1_time_ff;
         s2_side_ff <= s2_side_in;
      end
   end

   // Multiply the error length by the force limit in two halves
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_pl_ff   <= PL_W'(s2_len_ff[LEN_LO_W-1:0]) * PL_W'(s2_lim_ff);
         s3_ph_ff   <= PH_W'(s2_len_ff[LEN_W-1:LEN_LO_W]) * PH_W'(s2_lim_ff);
         s3_inum_ff <= s2_inum_ff;
         s3_time_ff <= s2_time_ff;
         s3_side_ff <= s2_side_ff;
      end
   end

   // Join the halves and fold the mass scale into a shift
   always_comb begin
      prod_sum   = PROD_W'(s3_pl_ff) + (PROD_W'(s3_ph_ff) << LEN_LO_W);
      s4_bnum_in = BR_NW'(prod_sum >> BR_SH);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_bnum_ff <= s4_bnum_in;
         s4_inum_ff <= s3_inum_ff;
         s4_time_ff <= s3_time_ff;
         s4_side_ff <= s3_side_ff;
      end
   end

   // Feed both divider chains
   assign br_rem[0] = '0;
   assign br_num[0] = DIV_W'(s4_bnum_ff);
   assign br_dvs[0] = cfg.mass;
   assign id_rem[0] = '0;
   assign id_num[0] = DIV_W'(s4_inum_ff);
   assign id_dvs[0] = s4_time_ff;

   for (genvar k = 0; k < DIV_W; k++) begin : g_div
      lbsc_div_cell u_br (
         .clock (clock),
         .adv   (adv),
         .rem_i (br_rem[k]),
         .num_i (br_num[k]),
         .dvs_i (br_dvs[k]),
         .rem_o (br_rem[k+1]),
         .num_o (br_num[k+1]),
         .dvs_o (br_dvs[k+1])
      );
      lbsc_div_cell u_id (
         .clock (clock),
         .adv   (adv),
         .rem_i (id_rem[k]),
         .num_i (id_num[k]),
         .dvs_i (id_dvs[k]),
         .rem_o (id_rem[k+1]),
         .num_o (id_num[k+1]),
         .dvs_o (id_dvs[k+1])
      );
   end

   // Carry the flags alongside the divider cells
   always_ff @(posedge clock) begin
      if (adv) begin
         dv_side_ff[0] <= s4_side_ff;
         for (int k = 1; k < DIV_W; k++) begin
            dv_side_ff[k] <= dv_side_ff[k-1];
         end
      end
   end

   // Cap the ideal speed and flag a brake quotient beyond 64 bits
   always_comb begin
      qx = QX_W'(br_num[DIV_W]);
      iq = id_num[DIV_W];
      sq_side_in       = dv_side_ff[DIV_W-1];
      sq_side_in.ovf   = |qx[QX_W-1:RAD_W];
      sq_side_in.ideal = (iq > DIV_W'(SPD_CAP)) ? SPD_CAP : iq[MAG_W-1:0];
   end

   assign sq_rad[0]  = qx[RAD_W-1:0];
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
      lbsc_sqrt_cell u_sq (
         .clock  (clock),
         .adv    (adv),
         .rad_i  (sq_rad[j]),
         .rem_i  (sq_rem[j]),
         .root_i (sq_root[j]),
         .rad_o  (sq_rad[j+1]),
         .rem_o  (sq_rem[j+1]),
         .root_o (sq_root[j+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_side_ff[0] <= sq_side_in;
         for (int j = 1; j < SQ_STEPS; j++) begin
            sq_side_ff[j] <= sq_side_ff[j-1];
         end
      end
   end

   // Lesser speed, signed, plus match; zero error: match; unlimited: signed ideal; saturate
   always_comb begin
      fin = sq_side_ff[SQ_STEPS-1];
      if (fin.lim_zero) begin
         mag_raw = '0;
      end else if (fin.mass_zero || fin.ovf) begin
         mag_raw = SPD_CAP;
      end else begin
         mag_raw = MAG_W'(sq_root[SQ_STEPS]);
      end
      mag  = (fin.ideal < mag_raw) ? fin.ideal : mag_raw;
      mext = RES_W'($signed(fin.match));
      iext = $signed({2'b00, fin.ideal});
      mval = $signed({2'b00, mag});
      if (fin.d_zero) begin
         res = mext;
      end else if (fin.unl) begin
         res = fin.dist_neg ? -iext : iext;
      end else begin
         res = (fin.d_neg ? -mval : mval) + mext;
      end
      if (res > RES_MAX) begin
         speed = RES_MAX[DATA_W-1:0];
         sat   = 1'b1;
      end else if (res < RES_MIN) begin
         speed = RES_MIN[DATA_W-1:0];
         sat   = 1'b1;
      end else begin
         speed = res[DATA_W-1:0];
         sat   = 1'b0;
      end
   end

endmodule

FILE: rtl/lbsc_checker.sv
// Port-level checks for the braking speed command core, bound to the top level.
module lbsc_checker import lbsc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_speed_x,
   input logic [DATA_W-1:0] rsp_speed_y,
   input logic              rsp_saturated
);

   // A stalled result item keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_speed_x) &&
         $stable(rsp_speed_y) && $stable(rsp_saturated))
      else $error("stalled result item changed");

   // No result item right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

   // Input side is open whenever the output register is free
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output register");

   // Taking a result always lets a new item in the same cycle
   a_ready_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> req_ready)
      else $error("input stalled while result taken");

endmodule

bind linear_braking_speed_command_core lbsc_checker u_lbsc_checker (.*);
